@@ rtl/pfd_pkg.sv @@
// ----------------------------------------------------------------------------
// pfd_pkg: shared types, constants and helpers of the filtered-derivative PID
// Fixed-point format, saturating add/subtract and magnitude saturation used
// by the serial multiplier, the serial divider and the sequencer.
// ----------------------------------------------------------------------------
package pfd_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int QUOT_W     = DATA_WIDTH + FRAC_BITS;
    localparam int MUL_CNT_W  = $clog2(DATA_WIDTH);
    localparam int DIV_CNT_W  = $clog2(QUOT_W);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_U_W    = 31;
    localparam int IN_TDATA_W = 2 * DATA_WIDTH;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_WEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_FACTOR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD   = 3'd5;

    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam data_t ONE_Q    = DATA_WIDTH'(1) << FRAC_BITS;
    localparam logic [CFG_U_W-1:0]    ONE_U      = CFG_U_W'(1) << FRAC_BITS;
    localparam logic [DATA_WIDTH-1:0] ROUND_HALF = DATA_WIDTH'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic  sat;
        data_t val;
    } sat_res_t;

    typedef struct packed {
        logic  start;
        data_t opa;
        data_t opb;
    } arith_req_t;

    typedef struct packed {
        logic  done;
        logic  sat;
        data_t val;
    } arith_rsp_t;

    // Absolute value as an unsigned word; the most negative value maps to 2^(W-1).
    function automatic logic [DATA_WIDTH-1:0] mag_of(data_t a);
        logic [DATA_WIDTH-1:0] u;
        u = a;
        return u[DATA_WIDTH-1] ? (~u + 1'b1) : u;
    endfunction

    // Signed result from a wide magnitude and a sign, clamped to the data range.
    function automatic sat_res_t sat_mag(logic [PROD_W-1:0] m, logic neg);
        logic     hi_nz;
        logic     rest_z;
        sat_res_t r;
        hi_nz  = |m[PROD_W-1:DATA_WIDTH];
        rest_z = ~|m[DATA_WIDTH-2:0];
        r.sat  = hi_nz | (m[DATA_WIDTH-1] & ~(neg & rest_z));
        if (r.sat) begin
            r.val = neg ? DATA_MIN : DATA_MAX;
        end else begin
            r.val = neg ? (~m[DATA_WIDTH-1:0] + 1'b1) : m[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

    // Saturating add or subtract of two data words.
    function automatic sat_res_t sat_add(data_t a, data_t b, logic sub);
        logic [DATA_WIDTH:0] s;
        sat_res_t            r;
        if (sub) begin
            s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
        end else begin
            s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
        end
        r.sat = s[DATA_WIDTH] ^ s[DATA_WIDTH-1];
        if (r.sat) begin
            r.val = s[DATA_WIDTH] ? DATA_MIN : DATA_MAX;
        end else begin
            r.val = s[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/pfd_mul.sv @@
// ----------------------------------------------------------------------------
// pfd_mul: bit-serial fixed-point multiplier
// Shift-and-add over the multiplier bits, one bit per cycle, with the rounding
// half preloaded; then round, rescale and saturate into the result register.
// ----------------------------------------------------------------------------
module pfd_mul
    import pfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  arith_req_t req,
    output arith_rsp_t rsp
);

    logic [DATA_WIDTH-1:0] mcand_reg;
    logic [DATA_WIDTH-1:0] hi_reg;
    logic [DATA_WIDTH-1:0] lo_reg;
    logic                  neg_reg;
    logic [MUL_CNT_W-1:0]  cnt_reg;
    logic                  busy_reg;
    logic                  fin_reg;
    logic                  done_reg;
    sat_res_t              res_reg;

    logic [DATA_WIDTH:0]   step_sum;
    logic [PROD_W-1:0]     prod_q;

    // Add the multiplicand into the upper half when the current bit is set.
    assign step_sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);
    assign prod_q   = {hi_reg, lo_reg} >> FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            mcand_reg <= mag_of(req.opa);
            lo_reg    <= mag_of(req.opb);
            hi_reg    <= ROUND_HALF;
            neg_reg   <= req.opa[DATA_WIDTH-1] ^ req.opb[DATA_WIDTH-1];
            cnt_reg   <= MUL_CNT_W'(DATA_WIDTH - 1);
        end else if (busy_reg) begin
            hi_reg  <= step_sum[DATA_WIDTH:1];
            lo_reg  <= {step_sum[0], lo_reg[DATA_WIDTH-1:1]};
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (fin_reg) begin
            res_reg <= sat_mag(prod_q, neg_reg);
        end
    end

    assign rsp.done = done_reg;
    assign rsp.sat  = res_reg.sat;
    assign rsp.val  = res_reg.val;

endmodule

@@ rtl/pfd_div.sv @@
// ----------------------------------------------------------------------------
// pfd_div: bit-serial fixed-point divider
// Restoring division of the magnitude of (num << FRAC_BITS) by the magnitude
// of den, one quotient bit per cycle, truncated toward zero and saturated.
// ----------------------------------------------------------------------------
module pfd_div
    import pfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  arith_req_t req,
    output arith_rsp_t rsp
);

    logic [DATA_WIDTH-1:0] dvs_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [QUOT_W-1:0]     dq_reg;
    logic                  neg_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic                  busy_reg;
    logic                  fin_reg;
    logic                  done_reg;
    sat_res_t              res_reg;

    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH+1:0] diff;
    logic                  fits;

    // Bring down the next dividend bit and trial-subtract the divisor.
    assign shifted = {rem_reg, dq_reg[QUOT_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign fits    = ~diff[DATA_WIDTH+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            dvs_reg <= mag_of(req.opb);
            rem_reg <= '0;
            dq_reg  <= {mag_of(req.opa), {FRAC_BITS{1'b0}}};
            neg_reg <= req.opa[DATA_WIDTH-1] ^ req.opb[DATA_WIDTH-1];
            cnt_reg <= DIV_CNT_W'(QUOT_W - 1);
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
            dq_reg  <= {dq_reg[QUOT_W-2:0], fits};
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (fin_reg) begin
            res_reg <= sat_mag({{(PROD_W-QUOT_W){1'b0}}, dq_reg}, neg_reg);
        end
    end

    assign rsp.done = done_reg;
    assign rsp.sat  = res_reg.sat;
    assign rsp.val  = res_reg.val;

endmodule

@@ rtl/pid_filtered_derivative.sv @@
// ----------------------------------------------------------------------------
// pid_filtered_derivative: PID controller, setpoint weighting, filtered D term
// Signed Q16.16 controller: P = Kp*(b*r - y), D = (Kd*Dp - N*h*Kd*(y - yp)) /
// (Kd + N*h), drive = P + I + D, then I += Ki*h*(r - y), all saturating.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------
//   s_      | in        | s_tvalid / s_tready       | s_tdata: measured,
//           |           |                           |   reference
//   m_      | out       | m_tvalid / m_tready       | m_tdata: drive;
//           |           |                           |   m_tuser: clipped
//   cfg_    | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// Each sample runs up to eight products through the shared bit-serial
// multiplier and, unless Kd + N*h is zero and the divide is skipped, one
// quotient through the bit-serial divider. A new sample can be accepted in
// the cycle after the previous result is handed to the output register,
// even while that result waits on m_tready.
// Reset (aresetn low, synchronous) loads the register defaults and clears the
// stored derivative, measurement and integral. cfg_ready is always high.
// ----------------------------------------------------------------------------
module pid_filtered_derivative
    import pfd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // sample input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,   // [31:0] measured, [63:32] reference
    // result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_WIDTH-1:0] m_tdata,   // [31:0] drive
    output logic [0:0]            m_tuser,   // [0] clipped
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_WIDTH-1:0] cfg_data
);

    // Sequencer: one state per arithmetic step.
    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_MUL_BR   = 14'b00000000000010,
        S_MUL_P    = 14'b00000000000100,
        S_MUL_NH   = 14'b00000000001000,
        S_CHK      = 14'b00000000010000,
        S_MUL_KDD  = 14'b00000000100000,
        S_MUL_NHKD = 14'b00000001000000,
        S_MUL_E    = 14'b00000010000000,
        S_DIV      = 14'b00000100000000,
        S_SUM      = 14'b00001000000000,
        S_SUM2     = 14'b00010000000000,
        S_MUL_KIH  = 14'b00100000000000,
        S_MUL_INC  = 14'b01000000000000,
        S_OUT      = 14'b10000000000000
    } state_t;

    // Configuration registers
    data_t               kp_reg;
    data_t               ki_reg;
    data_t               kd_reg;
    data_t               bw_reg;
    logic [CFG_U_W-1:0]  nf_reg;
    logic [CFG_U_W-1:0]  hp_reg;

    // Sequencer and working registers
    state_t state_reg, state_next;
    logic   go_reg, go_next;
    data_t  y_reg, y_next;
    data_t  r_reg, r_next;
    data_t  t_reg, t_next;
    data_t  p_reg, p_next;
    data_t  nh_reg, nh_next;
    data_t  den_reg, den_next;
    data_t  a_reg, a_next;
    data_t  d_reg, d_next;
    data_t  drive_reg, drive_next;
    logic   clip_reg, clip_next;

    // Controller state carried between samples
    data_t  last_deriv_reg, last_deriv_next;
    data_t  last_meas_reg, last_meas_next;
    data_t  integ_reg, integ_next;

    // Output register
    logic   m_valid_reg, m_valid_next;
    data_t  m_drive_reg, m_drive_next;
    logic   m_clip_reg, m_clip_next;

    arith_req_t mul_req, div_req;
    arith_rsp_t mul_rsp, div_rsp;
    sat_res_t   alu0, alu1;
    data_t      nf_q, hp_q;

    assign nf_q = {1'b0, nf_reg};
    assign hp_q = {1'b0, hp_reg};

    pfd_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    pfd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Operand selection for the shared multiplier; the divider always takes
    // the difference held in t_reg over the denominator.
    always_comb begin
        mul_req.start = go_reg && (state_reg != S_DIV);
        mul_req.opa   = '0;
        mul_req.opb   = '0;
        unique case (state_reg)
            S_MUL_BR: begin
                mul_req.opa = bw_reg;
                mul_req.opb = r_reg;
            end
            S_MUL_P: begin
                mul_req.opa = kp_reg;
                mul_req.opb = t_reg;
            end
            S_MUL_NH: begin
                mul_req.opa = nf_q;
                mul_req.opb = hp_q;
            end
            S_MUL_KDD: begin
                mul_req.opa = kd_reg;
                mul_req.opb = last_deriv_reg;
            end
            S_MUL_NHKD: begin
                mul_req.opa = nh_reg;
                mul_req.opb = kd_reg;
            end
            S_MUL_E: begin
                mul_req.opa = nh_reg;
                mul_req.opb = t_reg;
            end
            S_MUL_KIH: begin
                mul_req.opa = ki_reg;
                mul_req.opb = hp_q;
            end
            S_MUL_INC: begin
                mul_req.opa = a_reg;
                mul_req.opb = t_reg;
            end
            default: begin
            end
        endcase
    end

    assign div_req.start = go_reg && (state_reg == S_DIV);
    assign div_req.opa   = t_reg;
    assign div_req.opb   = den_reg;

    // Step through the sample; each arithmetic state waits for its unit.
    always_comb begin
        state_next      = state_reg;
        go_next         = 1'b0;
        y_next          = y_reg;
        r_next          = r_reg;
        t_next          = t_reg;
        p_next          = p_reg;
        nh_next         = nh_reg;
        den_next        = den_reg;
        a_next          = a_reg;
        d_next          = d_reg;
        drive_next      = drive_reg;
        clip_next       = clip_reg;
        last_deriv_next = last_deriv_reg;
        last_meas_next  = last_meas_reg;
        integ_next      = integ_reg;
        m_valid_next    = m_valid_reg;
        m_drive_next    = m_drive_reg;
        m_clip_next     = m_clip_reg;
        alu0            = '0;
        alu1            = '0;

        // Drop the output transaction once it is taken.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    y_next     = s_tdata[DATA_WIDTH-1:0];
                    r_next     = s_tdata[IN_TDATA_W-1:DATA_WIDTH];
                    clip_next  = 1'b0;
                    go_next    = 1'b1;
                    state_next = S_MUL_BR;
                end
            end
            S_MUL_BR: begin
                if (mul_rsp.done) begin
                    alu0       = sat_add(mul_rsp.val, y_reg, ALU_SUB);
                    t_next     = alu0.val;
                    clip_next  = clip_reg | mul_rsp.sat | alu0.sat;
                    go_next    = 1'b1;
                    state_next = S_MUL_P;
                end
            end
            S_MUL_P: begin
                if (mul_rsp.done) begin
                    p_next     = mul_rsp.val;
                    clip_next  = clip_reg | mul_rsp.sat;
                    go_next    = 1'b1;
                    state_next = S_MUL_NH;
                end
            end
            S_MUL_NH: begin
                if (mul_rsp.done) begin
                    alu0       = sat_add(kd_reg, mul_rsp.val, ALU_ADD);
                    nh_next    = mul_rsp.val;
                    den_next   = alu0.val;
                    clip_next  = clip_reg | mul_rsp.sat | alu0.sat;
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                // A zero denominator forces the derivative to zero.
                if (den_reg == '0) begin
                    d_next     = '0;
                    state_next = S_SUM;
                end else begin
                    alu0       = sat_add(y_reg, last_meas_reg, ALU_SUB);
                    t_next     = alu0.val;
                    clip_next  = clip_reg | alu0.sat;
                    go_next    = 1'b1;
                    state_next = S_MUL_KDD;
                end
            end
            S_MUL_KDD: begin
                if (mul_rsp.done) begin
                    a_next     = mul_rsp.val;
                    clip_next  = clip_reg | mul_rsp.sat;
                    go_next    = 1'b1;
                    state_next = S_MUL_NHKD;
                end
            end
            S_MUL_NHKD: begin
                if (mul_rsp.done) begin
                    nh_next    = mul_rsp.val;
                    clip_next  = clip_reg | mul_rsp.sat;
                    go_next    = 1'b1;
                    state_next = S_MUL_E;
                end
            end
            S_MUL_E: begin
                if (mul_rsp.done) begin
                    alu0       = sat_add(a_reg, mul_rsp.val, ALU_SUB);
                    t_next     = alu0.val;
                    clip_next  = clip_reg | mul_rsp.sat | alu0.sat;
                    go_next    = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    d_next     = div_rsp.val;
                    clip_next  = clip_reg | div_rsp.sat;
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                alu0       = sat_add(p_reg, integ_reg, ALU_ADD);
                t_next     = alu0.val;
                clip_next  = clip_reg | alu0.sat;
                state_next = S_SUM2;
            end
            S_SUM2: begin
                // Finish the drive, advance the stored history, form the error.
                alu0            = sat_add(t_reg, d_reg, ALU_ADD);
                alu1            = sat_add(r_reg, y_reg, ALU_SUB);
                drive_next      = alu0.val;
                t_next          = alu1.val;
                clip_next       = clip_reg | alu0.sat | alu1.sat;
                last_deriv_next = d_reg;
                last_meas_next  = y_reg;
                go_next         = 1'b1;
                state_next      = S_MUL_KIH;
            end
            S_MUL_KIH: begin
                if (mul_rsp.done) begin
                    a_next     = mul_rsp.val;
                    clip_next  = clip_reg | mul_rsp.sat;
                    go_next    = 1'b1;
                    state_next = S_MUL_INC;
                end
            end
            S_MUL_INC: begin
                if (mul_rsp.done) begin
                    alu0       = sat_add(integ_reg, mul_rsp.val, ALU_ADD);
                    integ_next = alu0.val;
                    clip_next  = clip_reg | mul_rsp.sat | alu0.sat;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                // Hold until the output register is free or being emptied.
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_drive_next = drive_reg;
                    m_clip_next  = clip_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and controller state, cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            go_reg         <= 1'b0;
            m_valid_reg    <= 1'b0;
            last_deriv_reg <= '0;
            last_meas_reg  <= '0;
            integ_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            go_reg         <= go_next;
            m_valid_reg    <= m_valid_next;
            last_deriv_reg <= last_deriv_next;
            last_meas_reg  <= last_meas_next;
            integ_reg      <= integ_next;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge aclk) begin
        y_reg       <= y_next;
        r_reg       <= r_next;
        t_reg       <= t_next;
        p_reg       <= p_next;
        nh_reg      <= nh_next;
        den_reg     <= den_next;
        a_reg       <= a_next;
        d_reg       <= d_next;
        drive_reg   <= drive_next;
        clip_reg    <= clip_next;
        m_drive_reg <= m_drive_next;
        m_clip_reg  <= m_clip_next;
    end

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg <= ONE_Q;
            ki_reg <= '0;
            kd_reg <= '0;
            bw_reg <= ONE_Q;
            nf_reg <= '0;
            hp_reg <= ONE_U;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PROP_GAIN:       kp_reg <= cfg_data;
                REG_INTEG_GAIN:      ki_reg <= cfg_data;
                REG_DERIV_GAIN:      kd_reg <= cfg_data;
                REG_SETPOINT_WEIGHT: bw_reg <= cfg_data;
                REG_FILTER_FACTOR:   nf_reg <= cfg_data[CFG_U_W-1:0];
                REG_SAMPLE_PERIOD:   hp_reg <= cfg_data[CFG_U_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_drive_reg;
    assign m_tuser   = m_clip_reg;
    assign cfg_ready = 1'b1;

endmodule

@@ test/pid_drive_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_drive_checker: drive and clip predictor for the filtered-derivative PID
// Watches the register, sample and result channels. Keeps its own copy of the
// gains and of the loop state, predicts each drive value on sample acceptance
// and compares every result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module pid_drive_checker
    import pfd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [DATA_WIDTH-1:0] m_tdata,
    input  logic [0:0]            m_tuser,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_WIDTH-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    localparam longint Q_MAX = longint'(DATA_MAX);
    localparam longint Q_MIN = longint'(DATA_MIN);

    typedef struct packed {
        data_t drive;
        logic  clipped;
    } drive_pred_t;

    drive_pred_t drive_pred_q[$];

    // gains and loop state, all held in the data range
    longint kp, ki, kd, bw, nf, hp;
    longint prev_deriv, prev_meas, integ_sum;
    bit     sat_hit;
    int     errs = 0;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic longint clamp_q(longint v);
        if (v > Q_MAX) begin
            sat_hit = 1'b1;
            return Q_MAX;
        end
        if (v < Q_MIN) begin
            sat_hit = 1'b1;
            return Q_MIN;
        end
        return v;
    endfunction

    function automatic longint unsigned abs_q(longint a);
        return (a < 0) ? longint'(-a) : a;
    endfunction

    // signed value from a magnitude; the negative side reaches one step further
    function automatic longint from_mag_q(longint unsigned m, bit neg);
        longint unsigned lim;
        lim = neg ? longint'(-Q_MIN) : longint'(Q_MAX);
        if (m > lim) begin
            sat_hit = 1'b1;
            return neg ? Q_MIN : Q_MAX;
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // exact product, rounded half away from zero on the magnitude
    function automatic longint mul_q(longint a, longint b);
        longint unsigned prod;
        prod = abs_q(a) * abs_q(b);
        prod = (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return from_mag_q(prod, (a < 0) != (b < 0));
    endfunction

    function automatic longint div_q(longint num, longint den);
        longint unsigned quot;
        quot = (abs_q(num) << FRAC_BITS) / abs_q(den);
        return from_mag_q(quot, (num < 0) != (den < 0));
    endfunction

    function automatic drive_pred_t step_controller(longint y, longint r);
        longint      p, nh, den, d, u, num;
        drive_pred_t res;
        sat_hit = 1'b0;
        p   = mul_q(kp, clamp_q(mul_q(bw, r) - y));
        nh  = mul_q(nf, hp);
        den = clamp_q(kd + nh);
        if (den == 0) begin
            d = 0;
        end else begin
            num = clamp_q(mul_q(kd, prev_deriv)
                          - mul_q(mul_q(nh, kd), clamp_q(y - prev_meas)));
            d   = div_q(num, den);
        end
        u = clamp_q(clamp_q(p + integ_sum) + d);
        prev_deriv = d;
        prev_meas  = y;
        // the integral update counts toward this sample's clip flag
        integ_sum  = clamp_q(integ_sum + mul_q(mul_q(ki, hp), clamp_q(r - y)));
        res.drive   = data_t'(u);
        res.clipped = sat_hit;
        return res;
    endfunction

    always @(posedge aclk) begin
        drive_pred_t exp_res;
        if (!aresetn) begin
            kp         = longint'(ONE_Q);
            ki         = 0;
            kd         = 0;
            bw         = longint'(ONE_Q);
            nf         = 0;
            hp         = longint'(ONE_U);
            prev_deriv = 0;
            prev_meas  = 0;
            integ_sum  = 0;
            drive_pred_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PROP_GAIN:       kp = longint'(data_t'(cfg_data));
                    REG_INTEG_GAIN:      ki = longint'(data_t'(cfg_data));
                    REG_DERIV_GAIN:      kd = longint'(data_t'(cfg_data));
                    REG_SETPOINT_WEIGHT: bw = longint'(data_t'(cfg_data));
                    REG_FILTER_FACTOR:   nf = longint'(cfg_data[CFG_U_W-1:0]);
                    REG_SAMPLE_PERIOD:   hp = longint'(cfg_data[CFG_U_W-1:0]);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                drive_pred_q.push_back(step_controller(
                    longint'(data_t'(s_tdata[DATA_WIDTH-1:0])),
                    longint'(data_t'(s_tdata[IN_TDATA_W-1:DATA_WIDTH]))));
            end
            if (m_tvalid && m_tready) begin
                if (drive_pred_q.size() == 0) begin
                    $error("drive transaction with nothing predicted: actual %0d",
                           $signed(m_tdata));
                    errs++;
                end else begin
                    exp_res = drive_pred_q.pop_front();
                    if ($signed(m_tdata) !== exp_res.drive) begin
                        $error("drive mismatch: expected %0d, actual %0d",
                               exp_res.drive, $signed(m_tdata));
                        errs++;
                    end
                    if (m_tuser[0] !== exp_res.clipped) begin
                        $error("clipped mismatch: expected %0b, actual %0b",
                               exp_res.clipped, m_tuser[0]);
                        errs++;
                    end
                end
            end
        end
        pending    <= drive_pred_q.size();
        fail_count <= errs;
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the filtered-derivative PID controller
// Writes gain settings between phases, feeds directed corner samples and then
// random control-loop trajectories with random gaps and back-pressure; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import pfd_pkg::*;

    // indices past the register file, written to prove they are ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam logic [DATA_WIDTH-1:0] U_MAX = {1'b0, {CFG_U_W{1'b1}}};

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DATA_WIDTH-1:0] m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [DATA_WIDTH-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    bit gaps_on = 1'b1;

    always #2 aclk = ~aclk;

    pid_filtered_derivative i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pid_drive_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Stall the result side in about one cycle in six while gaps are enabled.
    always @(posedge aclk) begin
        m_tready <= (gaps_on && $urandom_range(99) < 16) ? 1'b0 : 1'b1;
    end

    // Mostly moderate values around the working range, with full-range words
    // and the corner values mixed in.
    function automatic data_t pick_value(int unsigned span_bits);
        int unsigned v;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(6))
                    0: return DATA_MAX;
                    1: return DATA_MIN;
                    2: return '0;
                    3: return ONE_Q;
                    4: return -ONE_Q;
                    5: return data_t'(-1);
                    default: return data_t'(1);
                endcase
            end
            1, 2: return data_t'($urandom);
            default: begin
                v = $urandom_range((1 << (span_bits + 1)) - 1);
                return data_t'(v) - data_t'(1 << span_bits);
            end
        endcase
    endfunction

    // Filter factor and sample period: bit 31 of a full random word must be
    // dropped by the block.
    function automatic logic [DATA_WIDTH-1:0] pick_unsigned();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(2))
                    0: return '0;
                    1: return U_MAX;
                    default: return DATA_WIDTH'(ONE_U);
                endcase
            end
            1, 2: return $urandom;
            default: return $urandom_range(1 << 18);
        endcase
    endfunction

    // Hold the write until the register channel takes it; leave cfg_valid high
    // so back-to-back writes need no second assignment in one step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [DATA_WIDTH-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Write the whole register set, optionally poking the unused indices too.
    task automatic set_gains(input data_t kp_v, ki_v, kd_v, bw_v,
                             input logic [DATA_WIDTH-1:0] nf_v, hp_v,
                             input bit spare);
        if (spare) begin
            write_reg(REG_SPARE_LO, $urandom);
            write_reg(REG_SPARE_HI, $urandom);
        end
        write_reg(REG_PROP_GAIN,       kp_v);
        write_reg(REG_INTEG_GAIN,      ki_v);
        write_reg(REG_DERIV_GAIN,      kd_v);
        write_reg(REG_SETPOINT_WEIGHT, bw_v);
        write_reg(REG_FILTER_FACTOR,   nf_v);
        write_reg(REG_SAMPLE_PERIOD,   hp_v);
        cfg_valid <= 1'b0;
    endtask

    // Offer one sample after a random gap; s_tvalid stays high on return so
    // the next sample can follow without a bubble.
    task automatic push_sample(input data_t y, input data_t r);
        while (gaps_on && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r, y};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid and wait for every outstanding result transaction.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // A random trajectory: the measurement creeps, the setpoint steps now and
    // then, and a few samples are pure noise.
    task automatic run_trajectory(input int n_items);
        longint y;
        longint r;
        y = longint'(pick_value(20));
        r = longint'(pick_value(20));
        repeat (n_items) begin
            if ($urandom_range(99) < 15) begin
                push_sample(pick_value(20), pick_value(20));
            end else begin
                y = y + longint'($urandom_range(1 << 15)) - (1 << 14);
                if (y > (1 << 24) || y < -(1 << 24)) begin
                    y = 0;
                end
                if ($urandom_range(19) == 0) begin
                    r = longint'(pick_value(20));
                end
                push_sample(data_t'(y), data_t'(r));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset gains: no derivative path, so the divisor is zero. Drive the
        // sample fields to their extremes to saturate P and the drive sum.
        push_sample('0, '0);
        push_sample(DATA_MAX, DATA_MIN);
        push_sample(DATA_MIN, DATA_MAX);
        push_sample(DATA_MAX, DATA_MAX);
        push_sample(DATA_MIN, DATA_MIN);
        push_sample(ONE_Q, -ONE_Q);
        push_sample(data_t'(-1), data_t'(1));
        drain();

        // Kd cancels N*h exactly: zero divisor with a live derivative gain.
        // Poke the unused indices on the way.
        set_gains(ONE_Q, ONE_Q, -ONE_Q, ONE_Q, DATA_WIDTH'(ONE_U),
                  DATA_WIDTH'(ONE_U), 1'b1);
        push_sample(ONE_Q, 2 * ONE_Q);
        push_sample(-ONE_Q, ONE_Q);
        push_sample(DATA_MAX, '0);
        push_sample('0, DATA_MIN);
        drain();

        // Strong filtered derivative and a huge integral gain: swing the
        // measurement rail to rail to saturate D and the integral.
        set_gains(ONE_Q, DATA_MAX, ONE_Q, ONE_Q, DATA_WIDTH'(8 * ONE_U),
                  DATA_WIDTH'(ONE_U >> 4), 1'b0);
        push_sample(DATA_MAX, '0);
        push_sample(DATA_MIN, '0);
        push_sample(DATA_MAX, ONE_Q);
        push_sample('0, DATA_MAX);
        push_sample(DATA_MIN, DATA_MIN);
        push_sample(ONE_Q, ONE_Q);
        drain();

        // Register extremes, with bit 31 set on the unsigned registers.
        set_gains(DATA_MIN, DATA_MIN, DATA_MAX, DATA_MIN, '1, '1, 1'b0);
        push_sample(ONE_Q, -ONE_Q);
        push_sample(DATA_MIN, DATA_MAX);
        push_sample('0, '0);
        drain();
        set_gains(DATA_MAX, DATA_MAX, DATA_MIN, DATA_MAX, U_MAX, '0, 1'b0);
        push_sample(-ONE_Q, ONE_Q);
        push_sample(DATA_MAX, DATA_MIN);
        drain();

        // Random phases; one stretch runs with no gaps on either side.
        for (int ph = 0; ph < 38; ph++) begin
            gaps_on <= !(ph >= 12 && ph < 18);
            if (ph % 8 == 3) begin
                // hold the derivative path off so the divisor is zero
                set_gains(pick_value(18), pick_value(16), '0, pick_value(18),
                          '0, pick_unsigned(), $urandom_range(3) == 0);
            end else begin
                set_gains(pick_value(18), pick_value(16), pick_value(18),
                          pick_value(18), pick_unsigned(), pick_unsigned(),
                          $urandom_range(3) == 0);
            end
            run_trajectory(50);
            drain();
        end

        // Catch any stray result after the last expected one.
        repeat (400) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
